// ===== rtl/infix_to_postfix_converter_core_defines.svh =====
// Assertion macros for the converter checker.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2P_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define I2P_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/i2p_pkg.sv =====
// Types, codes and helpers for the infix to postfix converter.
package i2p_pkg;

  localparam logic [7:0] SYM_MUL = 8'h2A;
  localparam logic [7:0] SYM_DIV = 8'h2F;
  localparam logic [7:0] SYM_ADD = 8'h2B;
  localparam logic [7:0] SYM_SUB = 8'h2D;

  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_LOW  = 2'd2;
  localparam logic [1:0] RANK_HIGH = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } i2p_in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last_of_run;
    logic       expression_done;
    logic       overflow_error;
  } i2p_out_t;

  // Shift commands for the stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } i2p_stk_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_POP,
    ST_FLUSH
  } i2p_state_t;

  function automatic logic [1:0] rank_of(input logic [7:0] c);
    logic [1:0] r;
    r = RANK_NONE;
    if (c == SYM_MUL || c == SYM_DIV) begin
      r = RANK_HIGH;
    end else if (c == SYM_ADD || c == SYM_SUB) begin
      r = RANK_LOW;
    end
    return r;
  endfunction

endpackage

// ===== rtl/i2p_cell.sv =====
// One stack cell: holds an operator and shifts toward top or bottom.
module i2p_cell (
  input  logic                  clk,
  input  i2p_pkg::i2p_stk_ctrl_t ctrl,
  input  logic [7:0]            above,
  input  logic [7:0]            below,
  output logic [7:0]            entry
);
  import i2p_pkg::*;

  // Take the upper neighbor on push, the lower one on pop, else hold
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= above;
    end else if (ctrl.pop) begin
      entry <= below;
    end
  end

endmodule

// ===== rtl/i2p_stack.sv =====
// Operator stack built as a shifting row of cells, top at cell zero.
module i2p_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                   clk,
  input  i2p_pkg::i2p_stk_ctrl_t ctrl,
  input  logic [7:0]             push_sym,
  output logic [7:0]             top,
  output logic [7:0]             second
);
  import i2p_pkg::*;

  logic [7:0] entries [STACK_DEPTH];

  // Chain the cells; the top takes the new symbol, the bottom refills from itself
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] above;
    logic [7:0] below;
    if (i == 0) begin : g_top
      assign above = push_sym;
    end else begin : g_mid
      assign above = entries[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = entries[i];
    end else begin : g_rest
      assign below = entries[i+1];
    end
    i2p_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .above (above),
      .below (below),
      .entry (entries[i])
    );
  end

  assign top    = entries[0];
  assign second = entries[1];

endmodule

// ===== rtl/infix_to_postfix_converter_core.sv =====
// Top level of the infix to postfix converter (operator precedence, no parentheses).
//
// Input channel sym_*: one character word per transfer; end_of_expression marks
// the final character. Output channel pf_*: one postfix character word per
// transfer, with last_of_run on the final word caused by an input word,
// expression_done on the final word of the expression and overflow_error there
// if an operator was dropped because the stack was full.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// One word is worked on at a time; sym_stall is high from the cycle after an
// accept until that word's results are all in the output register.
// A non-operator's word goes through ST_EMIT; an operator pops in ST_POP, then is
// pushed if there is room; a flush pops each stacked entry in ST_FLUSH. Pops and
// the flush are set by the single shift port of the cell chain.
// The output register frees the input side: a new word is taken while the last
// result waits on a stalled receiver; pf_stall only holds the sequencer when a
// further result must be written.
// Reset empties the stack count and clears the overflow flag and pf_valid.
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sym_valid,
  output logic              sym_stall,
  input  i2p_pkg::i2p_in_t  sym_word,
  output logic              pf_valid,
  input  logic              pf_stall,
  output i2p_pkg::i2p_out_t pf_word
);
  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  i2p_state_t    state;
  i2p_state_t    state_next;
  i2p_in_t       cur;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovf_seen;
  logic          ovf_next;
  logic          emit;
  i2p_out_t      emit_word;
  i2p_stk_ctrl_t stk_ctrl;
  logic [7:0]    top;
  logic [7:0]    second;
  logic          can_emit;
  logic [1:0]    cur_rank;
  logic          pop_hit;
  logic          one_left;
  logic          full;

  i2p_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk      (clk),
    .ctrl     (stk_ctrl),
    .push_sym (cur.symbol),
    .top      (top),
    .second   (second)
  );

  assign can_emit = !pf_valid || !pf_stall;
  assign cur_rank = rank_of(cur.symbol);
  assign pop_hit  = (count != '0) && (rank_of(top) >= cur_rank);
  assign one_left = (count == CW'(1));
  assign full     = (count == CW'(STACK_DEPTH));
  assign sym_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sym_valid) begin
          state_next = (rank_of(sym_word.symbol) != RANK_NONE) ? ST_POP : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          state_next = (cur.end_of_expression && count != '0) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_POP: begin
        if (!pop_hit) begin
          state_next = cur.end_of_expression ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (can_emit && one_left) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Emitted word, stack shifts and bookkeeping
  always_comb begin
    emit       = 1'b0;
    emit_word  = '0;
    stk_ctrl   = '0;
    count_next = count;
    ovf_next   = ovf_seen;
    case (state)
      ST_IDLE: begin
      end
      ST_EMIT: begin
        if (can_emit) begin
          emit                      = 1'b1;
          emit_word.out_symbol      = cur.symbol;
          emit_word.last_of_run     = !(cur.end_of_expression && count != '0);
          emit_word.expression_done = cur.end_of_expression && count == '0;
          emit_word.overflow_error  = cur.end_of_expression && count == '0 && ovf_seen;
          if (cur.end_of_expression && count == '0) begin
            ovf_next = 1'b0;
          end
        end
      end
      ST_POP: begin
        if (pop_hit) begin
          if (can_emit) begin
            emit                  = 1'b1;
            emit_word.out_symbol  = top;
            emit_word.last_of_run = !cur.end_of_expression &&
                                    (one_left || rank_of(second) < cur_rank);
            stk_ctrl.pop          = 1'b1;
            count_next            = count - CW'(1);
          end
        end else if (!full) begin
          stk_ctrl.push = 1'b1;
          count_next    = count + CW'(1);
        end else begin
          ovf_next = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit                      = 1'b1;
          emit_word.out_symbol      = top;
          emit_word.last_of_run     = one_left;
          emit_word.expression_done = one_left;
          emit_word.overflow_error  = one_left && ovf_seen;
          stk_ctrl.pop              = 1'b1;
          count_next                = count - CW'(1);
          if (one_left) begin
            ovf_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ovf_seen <= 1'b0;
      pf_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf_seen <= ovf_next;
      if (emit) begin
        pf_valid <= 1'b1;
      end else if (!pf_stall) begin
        pf_valid <= 1'b0;
      end
    end
  end

  // Capture the accepted word and the emitted word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sym_valid) begin
      cur <= sym_word;
    end
    if (emit) begin
      pf_word <= emit_word;
    end
  end

endmodule

// ===== rtl/i2p_checker.sv =====
// Port-level checks for the converter, bound to the top level.
`include "infix_to_postfix_converter_core_defines.svh"

module i2p_checker (
  input logic              clk,
  input logic              rst,
  input logic              sym_valid,
  input logic              sym_stall,
  input i2p_pkg::i2p_in_t  sym_word,
  input logic              pf_valid,
  input logic              pf_stall,
  input i2p_pkg::i2p_out_t pf_word
);
  import i2p_pkg::*;

  // Hold a stalled output word
  `I2P_ASSERT_NEXT(a_out_hold, clk, rst, pf_valid && pf_stall, pf_valid && $stable(pf_word))
  // Close the run on the final word of an expression
  `I2P_ASSERT_NOW(a_done_last, clk, rst, pf_valid && pf_word.expression_done, pf_word.last_of_run)
  // Report overflow only on the final word of an expression
  `I2P_ASSERT_NOW(a_ovf_done, clk, rst, pf_valid && pf_word.overflow_error, pf_word.expression_done)
  // Take one input word at a time
  `I2P_ASSERT_NEXT(a_one_word, clk, rst, sym_valid && !sym_stall, sym_stall)

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (.*);

// ===== tb/sv/infix_to_postfix_converter_core_test.sv =====
// Self-checking testbench for the infix to postfix converter core.
`timescale 1ns / 1ps

module infix_to_postfix_converter_core_test;
  import i2p_pkg::*;

  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT     = 90;
  localparam int DRAIN_AT    = 180;
  localparam int CALM_FROM   = 300;
  localparam int CALM_TO     = 380;
  localparam int RANDOM_WORDS = 450;
  localparam int MAX_REPORTS = 10;

  // Track the operator stack and the postfix words it must produce
  class postfix_scoreboard;
    i2p_out_t   pending_postfix[$];
    logic [7:0] op_stack[DEPTH];
    int         stack_fill;
    bit         op_dropped;
    int         mismatches;
    int         checked;
    int         expressions;

    function int precedence(logic [7:0] c);
      case (c)
        SYM_MUL, SYM_DIV: return int'(RANK_HIGH);
        SYM_ADD, SYM_SUB: return int'(RANK_LOW);
        default:          return int'(RANK_NONE);
      endcase
    endfunction

    function void queue_word(logic [7:0] c);
      i2p_out_t w;
      w = '0;
      w.out_symbol = c;
      pending_postfix.push_back(w);
    endfunction

    // Note an accepted symbol word and queue the postfix words it causes
    function void take_symbol(i2p_in_t w);
      int       r;
      int       first;
      i2p_out_t tail;
      first = pending_postfix.size();
      r = precedence(w.symbol);
      if (r == int'(RANK_NONE)) begin
        queue_word(w.symbol);
      end else begin
        while (stack_fill > 0 && precedence(op_stack[stack_fill - 1]) >= r) begin
          stack_fill--;
          queue_word(op_stack[stack_fill]);
        end
        if (stack_fill < DEPTH) begin
          op_stack[stack_fill] = w.symbol;
          stack_fill++;
        end else begin
          op_dropped = 1'b1;
        end
      end
      // Flush top first on the final character
      if (w.end_of_expression) begin
        while (stack_fill > 0) begin
          stack_fill--;
          queue_word(op_stack[stack_fill]);
        end
        expressions++;
      end
      // Mark the final word of this symbol and of the expression
      if (pending_postfix.size() > first) begin
        tail = pending_postfix.pop_back();
        tail.last_of_run = 1'b1;
        if (w.end_of_expression) begin
          tail.expression_done = 1'b1;
          tail.overflow_error  = op_dropped;
        end
        pending_postfix.push_back(tail);
      end
      if (w.end_of_expression) begin
        op_dropped = 1'b0;
      end
    endfunction

    // Compare one accepted postfix word with the oldest expected one
    function void check_postfix(i2p_out_t got);
      i2p_out_t want;
      if (pending_postfix.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected word sym=%h last=%b done=%b ovf=%b", $realtime,
                   got.out_symbol, got.last_of_run, got.expression_done,
                   got.overflow_error);
        end
        return;
      end
      want = pending_postfix.pop_front();
      checked++;
      if (got.out_symbol !== want.out_symbol || got.last_of_run !== want.last_of_run ||
          got.expression_done !== want.expression_done ||
          got.overflow_error !== want.overflow_error) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch exp sym=%h last=%b done=%b ovf=%b", $realtime,
                   want.out_symbol, want.last_of_run, want.expression_done,
                   want.overflow_error);
          $display("%0t:          got sym=%h last=%b done=%b ovf=%b", $realtime,
                   got.out_symbol, got.last_of_run, got.expression_done,
                   got.overflow_error);
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     sym_valid;
  logic     sym_stall;
  i2p_in_t  sym_word;
  logic     pf_valid;
  logic     pf_stall;
  i2p_out_t pf_word;

  postfix_scoreboard sb = new;
  int n_sent;
  int quiet_cycles;
  bit hold_req;
  bit calm;

  infix_to_postfix_converter_core #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .sym_valid(sym_valid),
    .sym_stall(sym_stall),
    .sym_word (sym_word),
    .pf_valid (pf_valid),
    .pf_stall (pf_stall),
    .pf_word  (pf_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check output words and watch for a stuck handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (pf_valid && !pf_stall) begin
        sb.check_postfix(pf_word);
      end
      if ((pf_valid && !pf_stall) || (sym_valid && !sym_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Drive the receiver stall: random idling, a calm stretch and one long hold
  initial begin
    pf_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pf_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        pf_stall <= !calm && ($urandom_range(0, 99) < 20);
      end
    end
  end

  // Offer one symbol word and hold it until accepted; starts and ends at a falling edge
  task automatic send_word(input logic [7:0] s, input bit eoe);
    i2p_in_t w;
    w.symbol = s;
    w.end_of_expression = eoe;
    calm = (n_sent >= CALM_FROM && n_sent < CALM_TO);
    if (n_sent == HOLD_AT) begin
      hold_req = 1'b1;
    end
    // Pause until the block has drained
    if (n_sent == DRAIN_AT) begin
      while (sb.pending_postfix.size() > 0) begin
        sym_valid <= 1'b0;
        @(negedge clk);
      end
    end
    while (!calm && $urandom_range(0, 99) < 20) begin
      sym_valid <= 1'b0;
      @(negedge clk);
    end
    sym_valid <= 1'b1;
    sym_word  <= w;
    @(posedge clk);
    while (sym_stall) @(posedge clk);
    sb.take_symbol(w);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_operand();
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    while (s inside {SYM_MUL, SYM_DIV, SYM_ADD, SYM_SUB}) begin
      s = 8'($urandom_range(0, 255));
    end
    return s;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return SYM_MUL;
      1:       return SYM_DIV;
      2:       return SYM_ADD;
      default: return SYM_SUB;
    endcase
  endfunction

  // Send a well-formed expression: operand, operator, ..., operand
  task automatic send_expression(input int operands);
    for (int i = 0; i < operands; i++) begin
      send_word(random_operand(), i == operands - 1);
      if (i < operands - 1) begin
        send_word(random_operator(), 1'b0);
      end
    end
  endtask

  // Send a broken run: any bytes, repeated operators, random end marks
  task automatic send_noise(input int len);
    logic [7:0] s;
    for (int i = 0; i < len; i++) begin
      s = ($urandom_range(0, 1) == 0) ? random_operator() : 8'($urandom_range(0, 255));
      send_word(s, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst       = 1'b1;
    sym_valid = 1'b0;
    sym_word  = '0;
    n_sent    = 0;
    quiet_cycles = 0;
    hold_req  = 1'b0;
    calm      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: byte extremes, each operator, pops by rank and flushes
    send_word(8'h00, 1'b0);
    send_word(SYM_ADD, 1'b0);     // empty stack pushes at once
    send_word(8'hFF, 1'b0);
    send_word(SYM_MUL, 1'b0);     // higher rank stacks on top
    send_word(8'h7F, 1'b0);
    send_word(SYM_SUB, 1'b0);     // pops both
    send_word(8'h80, 1'b0);
    send_word(SYM_DIV, 1'b0);
    send_word(8'h41, 1'b1);       // flush two
    send_word(SYM_MUL, 1'b1);     // lone operator as the final character
    send_word(SYM_ADD, 1'b0);
    send_word(SYM_SUB, 1'b1);     // same rank pops, then flush
    send_word(8'h78, 1'b1);       // single operand expression
    send_word(8'h61, 1'b0);
    send_word(SYM_DIV, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(SYM_MUL, 1'b0);     // same high rank pops
    send_word(8'h63, 1'b0);
    send_word(SYM_ADD, 1'b0);     // low rank pops high
    send_word(8'h64, 1'b0);
    send_word(SYM_DIV, 1'b0);
    send_word(8'h65, 1'b1);

    // Random: mostly well-formed expressions, some broken runs
    while (n_sent < 22 + RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 85) begin
        send_expression($urandom_range(1, 8));
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
    send_word(random_operand(), 1'b1);
    sym_valid <= 1'b0;

    // Drain, then watch for stray words
    while (sb.pending_postfix.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d symbol words in %0d expressions; checked %0d postfix words.",
             n_sent, sb.expressions, sb.checked);
    $display("Covered pops by rank, flushes, long output hold and full drain; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_postfix.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2p_pkg.sv
rtl/i2p_cell.sv
rtl/i2p_stack.sv
rtl/infix_to_postfix_converter_core.sv
rtl/i2p_checker.sv
tb/sv/infix_to_postfix_converter_core_test.sv
